// ----- design/xmodem_crc_block_sender_macros.svh -----
// assertion helpers used by the checker file
`ifndef XMODEM_CRC_BLOCK_SENDER_MACROS_SVH
`define XMODEM_CRC_BLOCK_SENDER_MACROS_SVH

// clocked check, off while reset is low
`define XCBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also covers reset
`define XCBS_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/xcbs_pkg.sv -----
package xcbs_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam logic [7:0]  BlockCnt   = 8'(BlockBytes);
  localparam logic [15:0] CrcPoly    = 16'h1021;

  localparam logic [7:0] SohByte = 8'h01;
  localparam logic [7:0] AckByte = 8'h06;
  localparam logic [7:0] EotByte = 8'h04;
  localparam logic [7:0] PadByte = 8'hFF;

  // request queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    REQ_DATA   = 2'd0,
    REQ_PAD    = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_REPLY  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_REPLY = 3'd2,
    ST_BUSY      = 3'd3,
    ST_FIN_MID   = 3'd4
  } status_e;

  // one request's worth of output bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            tx_valid;
    status_e         status;
    logic [7:0]      bytes_in_block;
  } job_t;

  // crc-16, poly 0x1021, msb first, one data byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- design/xcbs_front.sv -----
module xcbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output xcbs_pkg::job_t    q_job_o
);

  typedef enum logic [6:0] {
    PH_SEND   = 7'b0000001,
    PH_WACK   = 7'b0000010,
    PH_WFIN   = 7'b0000100,
    PH_DONE   = 7'b0001000,
    PH_EREPLY = 7'b0010000,
    PH_EBUSY  = 7'b0100000,
    PH_EFIN   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  bc_q, bc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  bn_q, bn_d;

  xcbs_pkg::req_type_e req;
  xcbs_pkg::job_t      job;
  logic [7:0]          data_b;
  logic [15:0]         crc_next;
  logic [7:0]          bc_inc;
  logic                accept;

  assign req        = xcbs_pkg::req_type_e'(req_type_i);
  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_job_o    = job;

  assign data_b   = (req == xcbs_pkg::REQ_PAD) ? xcbs_pkg::PadByte : data_byte_i;
  assign crc_next = xcbs_pkg::crc_byte(crc_q, data_b);
  assign bc_inc   = bc_q + 8'd1;

  always_comb begin
    phase_d      = phase_q;
    bc_d         = bc_q;
    crc_d        = crc_q;
    bn_d         = bn_q;
    job          = '0;
    job.status   = xcbs_pkg::ST_OK;
    unique case (phase_q)
      PH_SEND: begin
        if (req == xcbs_pkg::REQ_DATA || req == xcbs_pkg::REQ_PAD) begin
          job.tx_valid = 1'b1;
          crc_d        = crc_next;
          bc_d         = bc_inc;
          if (bc_q == 8'd0) begin
            // block header ahead of the first data byte
            job.bytes    = {data_b, ~bn_q, bn_q, xcbs_pkg::SohByte};
            job.last_idx = 2'd3;
          end else if (bc_inc == xcbs_pkg::BlockCnt) begin
            job.bytes    = {8'h00, crc_next[7:0], crc_next[15:8], data_b};
            job.last_idx = 2'd2;
            phase_d      = PH_WACK;
          end else begin
            job.bytes[0] = data_b;
          end
        end else if (req == xcbs_pkg::REQ_FINISH) begin
          if (bc_q == 8'd0) begin
            job.tx_valid = 1'b1;
            job.bytes[0] = xcbs_pkg::EotByte;
            phase_d      = PH_WFIN;
          end else begin
            job.status = xcbs_pkg::ST_FIN_MID;
            phase_d    = PH_EFIN;
          end
        end
      end
      PH_WACK: begin
        if (req == xcbs_pkg::REQ_REPLY) begin
          if (data_byte_i == xcbs_pkg::AckByte) begin
            bn_d    = bn_q + 8'd1;
            bc_d    = 8'd0;
            crc_d   = 16'd0;
            phase_d = PH_SEND;
          end else begin
            job.status = xcbs_pkg::ST_BAD_REPLY;
            phase_d    = PH_EREPLY;
          end
        end else begin
          job.status = xcbs_pkg::ST_BUSY;
          phase_d    = PH_EBUSY;
        end
      end
      PH_WFIN: begin
        if (req == xcbs_pkg::REQ_REPLY) begin
          if (data_byte_i == xcbs_pkg::AckByte) begin
            job.status = xcbs_pkg::ST_DONE;
            phase_d    = PH_DONE;
          end else begin
            job.status = xcbs_pkg::ST_BAD_REPLY;
            phase_d    = PH_EREPLY;
          end
        end else begin
          job.status = xcbs_pkg::ST_BUSY;
          phase_d    = PH_EBUSY;
        end
      end
      PH_DONE:   job.status = xcbs_pkg::ST_DONE;
      PH_EREPLY: job.status = xcbs_pkg::ST_BAD_REPLY;
      PH_EBUSY:  job.status = xcbs_pkg::ST_BUSY;
      PH_EFIN:   job.status = xcbs_pkg::ST_FIN_MID;
      default:   job.status = xcbs_pkg::ST_FIN_MID;
    endcase
    job.bytes_in_block = bc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEND;
      bc_q    <= 8'd0;
      crc_q   <= 16'd0;
      bn_q    <= 8'd1;
    end else if (accept) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      crc_q   <= crc_d;
      bn_q    <= bn_d;
    end
  end

endmodule

// ----- design/xcbs_fifo.sv -----
module xcbs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcbs_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output xcbs_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = xcbs_pkg::PtrW;
  localparam int unsigned CntW = xcbs_pkg::CntW;

  xcbs_pkg::job_t mem_q [xcbs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(xcbs_pkg::QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(xcbs_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(xcbs_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- design/xcbs_back.sv -----
module xcbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  xcbs_pkg::job_t q_job_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     tx_byte_o,
  output logic           tx_valid_o,
  output logic           last_o,
  output logic [2:0]     status_o,
  output logic [7:0]     bytes_in_block_o
);

  xcbs_pkg::job_t cur_q;
  logic [1:0]     idx_q;
  logic           busy_q;
  logic           out_acc;
  logic           is_last;
  logic           load;

  assign is_last = (idx_q == cur_q.last_idx);
  assign out_acc = busy_q && !out_stall_i;
  assign load    = q_valid_i && (!busy_q || (out_acc && is_last));
  assign q_pop_o = load;

  assign out_valid_o      = busy_q;
  assign tx_byte_o        = cur_q.bytes[idx_q];
  assign tx_valid_o       = cur_q.tx_valid;
  assign last_o           = is_last;
  assign status_o         = cur_q.status;
  assign bytes_in_block_o = cur_q.bytes_in_block;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (out_acc) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_job_i;
    end
  end

endmodule

// ----- design/xmodem_crc_block_sender.sv -----
// a request's job is registered in the queue and then in the back before it is output
// throughput: one result per cycle while out_stall_i is low; a request has 1 to 4
//   results (4 at a block start), handed out by the single output serializer
// a 2-entry queue lets new requests in while earlier results wait on stall
// reset: async active low; block number 1, empty block, crc 0, queue empty
module xmodem_crc_block_sender (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       last_o,
  output logic [2:0] status_o,
  output logic [7:0] bytes_in_block_o
);

  // front to queue
  xcbs_pkg::job_t push_job;
  logic           push;
  logic           q_full;

  // queue to back
  xcbs_pkg::job_t pop_job;
  logic           pop;
  logic           q_valid;

  // front: protocol state, block framing and crc, one request per cycle while the queue is not full;
  // each request becomes a job of up to four output bytes plus status
  xcbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_job_o     (push_job)
  );

  // short job queue decoupling the front from output back-pressure
  xcbs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // back: holds the current job and hands out its bytes one per cycle unless out_stall_i is high;
  // the next job is loaded in the same cycle the last byte is taken
  xcbs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_job_i          (pop_job),
    .q_pop_o          (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tx_byte_o        (tx_byte_o),
    .tx_valid_o       (tx_valid_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .bytes_in_block_o (bytes_in_block_o)
  );

endmodule

// ----- design/xcbs_checker.sv -----
`include "xmodem_crc_block_sender_macros.svh"

module xcbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] req_type_i,
  input logic [7:0] data_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       tx_valid_o,
  input logic       last_o,
  input logic [2:0] status_o,
  input logic [7:0] bytes_in_block_o
);

  // any non-ok status, once delivered, sticks until reset
  logic [2:0] seen_q, seen_d;

  assign seen_d = (out_valid_o && !out_stall_i && status_o != xcbs_pkg::ST_OK) ?
                  status_o : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= xcbs_pkg::ST_OK;
    end else begin
      seen_q <= seen_d;
    end
  end

  `XCBS_ASSERT_NORST(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o,
    "busy in reset")
  `XCBS_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o) && $stable(last_o)
      && $stable(status_o), "stalled result changed")
  `XCBS_ASSERT(a_nobyte_zero, out_valid_o && !tx_valid_o |-> tx_byte_o == 8'h00 && last_o,
    "empty result not lone zero")
  `XCBS_ASSERT(a_status_sticky,
    out_valid_o && seen_q != xcbs_pkg::ST_OK |-> status_o == seen_q, "held status lost")
  `XCBS_ASSERT(a_count_range, out_valid_o |-> bytes_in_block_o <= xcbs_pkg::BlockCnt,
    "block count overflow")

endmodule

bind xmodem_crc_block_sender xcbs_checker u_checker (.*);
